// File: sv/rgb_to_hsv_converter_macros.svh
// ----------------------------------------------------------------------------
// RGB to HSV converter assertion macros
// Shared concurrent assertion forms for the converter RTL.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERTER_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define RHC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define RHC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define RHC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/rhc_pkg.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter package
// Payload types, pipeline record and arithmetic constants.
// ----------------------------------------------------------------------------
package rhc_pkg;

    localparam int CHAN_BITS  = 8;
    localparam int HUE_BITS   = 15;
    localparam int HUE_Q_BITS = 12;
    localparam int SAT_Q_BITS = 8;
    localparam int DIV_BITS   = 4;

    localparam logic [HUE_BITS-1:0] HUE_SECTOR     = HUE_BITS'(3840);
    localparam logic [HUE_BITS-1:0] HUE_TURN       = HUE_BITS'(23040);
    localparam logic [HUE_BITS-1:0] HUE_BASE_GREEN = HUE_BITS'(2 * 3840);
    localparam logic [HUE_BITS-1:0] HUE_BASE_BLUE  = HUE_BITS'(4 * 3840);

    typedef enum logic [1:0] {
        SECTOR_RED,
        SECTOR_GREEN,
        SECTOR_BLUE
    } sector_t;

    typedef struct packed {
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [HUE_BITS-1:0]  hue;
        logic [CHAN_BITS-1:0] saturation;
        logic [CHAN_BITS-1:0] value;
        logic                 hue_defined;
    } hsv_t;

    // One pixel in flight. The work fields start as the low dividend bits
    // and fill with quotient bits as the division stages shift them out.
    typedef struct packed {
        logic                  hue_defined;
        logic                  neg;
        sector_t               sector;
        logic [CHAN_BITS-1:0]  value;
        logic [CHAN_BITS-1:0]  delta;
        logic [CHAN_BITS-1:0]  hue_rem;
        logic [HUE_Q_BITS-1:0] hue_work;
        logic [CHAN_BITS-1:0]  sat_rem;
        logic [SAT_Q_BITS-1:0] sat_work;
    } pipe_t;

endpackage

// File: sv/rhc_div_step.sv
// ----------------------------------------------------------------------------
// Restoring division slice
// Retires four quotient bits of an 8-bit divisor long division.
// ----------------------------------------------------------------------------
module rhc_div_step (
    input  logic [rhc_pkg::CHAN_BITS-1:0] rem_in,
    input  logic [rhc_pkg::CHAN_BITS-1:0] divisor,
    input  logic [rhc_pkg::DIV_BITS-1:0]  bits_in,
    output logic [rhc_pkg::CHAN_BITS-1:0] rem_out,
    output logic [rhc_pkg::DIV_BITS-1:0]  quot_out
);
    import rhc_pkg::*;

    // The partial remainder stays below the divisor, so it fits in 8 bits.
    always_comb
    begin : step_logic
        logic [CHAN_BITS:0]   trial;
        logic [CHAN_BITS-1:0] rem;
        rem      = rem_in;
        trial    = '0;
        quot_out = '0;
        for (int i = DIV_BITS - 1; i >= 0; i--)
        begin
            trial = {rem, bits_in[i]};
            if (trial >= {1'b0, divisor})
            begin
                rem         = CHAN_BITS'(trial - {1'b0, divisor});
                quot_out[i] = 1'b1;
            end
            else
            begin
                rem = trial[CHAN_BITS-1:0];
            end
        end
        rem_out = rem;
    end

endmodule

// File: sv/rgb_to_hsv_converter.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter
// Streams 8-bit RGB pixels to fixed-point HSV, one pixel per clock while not stalled.
// ----------------------------------------------------------------------------
// The converter accepts one pixel in every clock unless output back pressure
// has filled every stage. Its HSV result passes through stages 1 to 4 and the
// output register and can be taken at the next edge. Hue is in degrees times 64
// (0 to 23039), saturation and value use 255 for 1.0. Black and grey pixels
// return hue 0 and saturation 0 with hue_defined low. The latency is set by the
// hue quotient, twelve bits wide, which three division stages retire four bits
// at a time; the saturation quotient finishes one stage earlier. Every stage
// holds its pixel while the next one is full and stalled, and empty stages fill
// even while a finished result waits, so no pixel is lost or repeated under
// back pressure.
module rgb_to_hsv_converter (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pixel_valid,
    output logic            pixel_ready,
    input  rhc_pkg::pixel_t pixel,
    output logic            hsv_valid,
    input  logic            hsv_ready,
    output rhc_pkg::hsv_t   hsv
);
    import rhc_pkg::*;

    `include "rgb_to_hsv_converter_macros.svh"

    // Valid bits for the four working stages and the output register.
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic s4_valid_reg, s4_valid_next;
    logic out_valid_reg, out_valid_next;

    // A stage may load when it is empty or its content moves on this cycle.
    logic s1_ready, s2_ready, s3_ready, s4_ready, out_ready;

    pipe_t s1_reg, s1_next;
    pipe_t s2_reg, s2_next;
    pipe_t s3_reg, s3_next;
    pipe_t s4_reg, s4_next;
    hsv_t  hsv_reg, hsv_next;

    assign out_ready = !out_valid_reg || hsv_ready;
    assign s4_ready  = !s4_valid_reg || out_ready;
    assign s3_ready  = !s3_valid_reg || s4_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;

    assign pixel_ready = s1_ready;
    assign hsv_valid   = out_valid_reg;
    assign hsv         = hsv_reg;

    assign s1_valid_next  = s1_ready  ? pixel_valid  : s1_valid_reg;
    assign s2_valid_next  = s2_ready  ? s1_valid_reg : s2_valid_reg;
    assign s3_valid_next  = s3_ready  ? s2_valid_reg : s3_valid_reg;
    assign s4_valid_next  = s4_ready  ? s3_valid_reg : s4_valid_reg;
    assign out_valid_next = out_ready ? s4_valid_reg : out_valid_reg;

    // ------------------------------------------------------------------
    // Stage 1: extremes, sector, signed difference and both dividends.
    // Hue dividend is |diff| * 3840 = (|diff| * 15) << 8, saturation
    // dividend is delta * 255 = (delta << 8) - delta.
    // ------------------------------------------------------------------
    always_comb
    begin : prep_logic
        logic [CHAN_BITS-1:0]  mx;
        logic [CHAN_BITS-1:0]  mn;
        logic [CHAN_BITS-1:0]  delta;
        logic [CHAN_BITS:0]    diff;
        logic [CHAN_BITS-1:0]  mag;
        logic [HUE_Q_BITS-1:0] mag15;
        logic [2*CHAN_BITS-1:0] sat_num;
        sector_t               sector;

        mx = (pixel.red > pixel.green) ? pixel.red : pixel.green;
        if (pixel.blue > mx)
        begin
            mx = pixel.blue;
        end
        mn = (pixel.red < pixel.green) ? pixel.red : pixel.green;
        if (pixel.blue < mn)
        begin
            mn = pixel.blue;
        end
        delta = mx - mn;

        // Ties go to red first, then green.
        if (pixel.red == mx)
        begin
            sector = SECTOR_RED;
        end
        else if (pixel.green == mx)
        begin
            sector = SECTOR_GREEN;
        end
        else
        begin
            sector = SECTOR_BLUE;
        end

        case (sector)
            SECTOR_RED:   diff = {1'b0, pixel.green} - {1'b0, pixel.blue};
            SECTOR_GREEN: diff = {1'b0, pixel.blue} - {1'b0, pixel.red};
            SECTOR_BLUE:  diff = {1'b0, pixel.red} - {1'b0, pixel.green};
            default:      diff = '0;
        endcase

        mag     = diff[CHAN_BITS] ? CHAN_BITS'(-diff) : diff[CHAN_BITS-1:0];
        mag15   = {mag, 4'b0000} - {4'b0000, mag};
        sat_num = {delta, {CHAN_BITS{1'b0}}} - {{CHAN_BITS{1'b0}}, delta};

        s1_next.hue_defined = (delta != '0);
        s1_next.neg         = diff[CHAN_BITS];
        s1_next.sector      = sector;
        s1_next.value       = mx;
        s1_next.delta       = delta;
        // The quotient fits in twelve bits, so the top eight dividend bits
        // already sit below the divisor and seed the remainder.
        s1_next.hue_rem     = mag15[HUE_Q_BITS-1:HUE_Q_BITS-CHAN_BITS];
        s1_next.hue_work    = {mag15[HUE_Q_BITS-CHAN_BITS-1:0], {CHAN_BITS{1'b0}}};
        s1_next.sat_rem     = sat_num[2*CHAN_BITS-1:CHAN_BITS];
        s1_next.sat_work    = sat_num[CHAN_BITS-1:0];
    end

    // ------------------------------------------------------------------
    // Stages 2 to 4: long division, four quotient bits per stage. Each
    // work field shifts left, and the new quotient bits enter at the bottom.
    // ------------------------------------------------------------------
    logic [CHAN_BITS-1:0] hue_rem_a, hue_rem_b, hue_rem_c;
    logic [DIV_BITS-1:0]  hue_q_a, hue_q_b, hue_q_c;
    logic [CHAN_BITS-1:0] sat_rem_a, sat_rem_b;
    logic [DIV_BITS-1:0]  sat_q_a, sat_q_b;

    rhc_div_step u_hue_step_a (
        .rem_in   (s1_reg.hue_rem),
        .divisor  (s1_reg.delta),
        .bits_in  (s1_reg.hue_work[HUE_Q_BITS-1 -: DIV_BITS]),
        .rem_out  (hue_rem_a),
        .quot_out (hue_q_a)
    );

    rhc_div_step u_sat_step_a (
        .rem_in   (s1_reg.sat_rem),
        .divisor  (s1_reg.value),
        .bits_in  (s1_reg.sat_work[SAT_Q_BITS-1 -: DIV_BITS]),
        .rem_out  (sat_rem_a),
        .quot_out (sat_q_a)
    );

    always_comb
    begin
        s2_next          = s1_reg;
        s2_next.hue_rem  = hue_rem_a;
        s2_next.hue_work = {s1_reg.hue_work[HUE_Q_BITS-DIV_BITS-1:0], hue_q_a};
        s2_next.sat_rem  = sat_rem_a;
        s2_next.sat_work = {s1_reg.sat_work[SAT_Q_BITS-DIV_BITS-1:0], sat_q_a};
    end

    rhc_div_step u_hue_step_b (
        .rem_in   (s2_reg.hue_rem),
        .divisor  (s2_reg.delta),
        .bits_in  (s2_reg.hue_work[HUE_Q_BITS-1 -: DIV_BITS]),
        .rem_out  (hue_rem_b),
        .quot_out (hue_q_b)
    );

    rhc_div_step u_sat_step_b (
        .rem_in   (s2_reg.sat_rem),
        .divisor  (s2_reg.value),
        .bits_in  (s2_reg.sat_work[SAT_Q_BITS-1 -: DIV_BITS]),
        .rem_out  (sat_rem_b),
        .quot_out (sat_q_b)
    );

    always_comb
    begin
        s3_next          = s2_reg;
        s3_next.hue_rem  = hue_rem_b;
        s3_next.hue_work = {s2_reg.hue_work[HUE_Q_BITS-DIV_BITS-1:0], hue_q_b};
        s3_next.sat_rem  = sat_rem_b;
        s3_next.sat_work = {s2_reg.sat_work[SAT_Q_BITS-DIV_BITS-1:0], sat_q_b};
    end

    // The saturation quotient is complete after stage 3 and rides along.
    rhc_div_step u_hue_step_c (
        .rem_in   (s3_reg.hue_rem),
        .divisor  (s3_reg.delta),
        .bits_in  (s3_reg.hue_work[HUE_Q_BITS-1 -: DIV_BITS]),
        .rem_out  (hue_rem_c),
        .quot_out (hue_q_c)
    );

    always_comb
    begin
        s4_next          = s3_reg;
        s4_next.hue_rem  = hue_rem_c;
        s4_next.hue_work = {s3_reg.hue_work[HUE_Q_BITS-DIV_BITS-1:0], hue_q_c};
    end

    // ------------------------------------------------------------------
    // Output stage: add the sector base, apply the sign and wrap a negative
    // hue by a full turn. Only the red sector can go below zero.
    // ------------------------------------------------------------------
    always_comb
    begin : hue_logic
        logic [HUE_BITS-1:0] base;
        logic [HUE_BITS:0]   quot;
        logic [HUE_BITS:0]   hue_sum;

        case (s4_reg.sector)
            SECTOR_RED:   base = '0;
            SECTOR_GREEN: base = HUE_BASE_GREEN;
            SECTOR_BLUE:  base = HUE_BASE_BLUE;
            default:      base = '0;
        endcase

        quot    = {{(HUE_BITS + 1 - HUE_Q_BITS){1'b0}}, s4_reg.hue_work};
        hue_sum = s4_reg.neg ? ({1'b0, base} - quot) : ({1'b0, base} + quot);
        if (hue_sum[HUE_BITS])
        begin
            hue_sum = hue_sum + {1'b0, HUE_TURN};
        end

        hsv_next.value       = s4_reg.value;
        hsv_next.hue_defined = s4_reg.hue_defined;
        if (s4_reg.hue_defined)
        begin
            hsv_next.hue        = hue_sum[HUE_BITS-1:0];
            hsv_next.saturation = s4_reg.sat_work;
        end
        else
        begin
            hsv_next.hue        = '0;
            hsv_next.saturation = '0;
        end
    end

    // ------------------------------------------------------------------
    // Registers. Only the valid bits are reset.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            s4_valid_reg  <= s4_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_reg <= s1_next;
        end
        if (s2_ready)
        begin
            s2_reg <= s2_next;
        end
        if (s3_ready)
        begin
            s3_reg <= s3_next;
        end
        if (s4_ready)
        begin
            s4_reg <= s4_next;
        end
        if (out_ready)
        begin
            hsv_reg <= hsv_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `RHC_ASSERT_SAME(a_hue_in_range, clk, rst_n, hsv_valid && hsv.hue_defined, hsv.hue < HUE_TURN)
    `RHC_ASSERT_SAME(a_undefined_zero, clk, rst_n, hsv_valid && !hsv.hue_defined, (hsv.hue == '0) && (hsv.saturation == '0))
    `RHC_ASSERT_SAME(a_sat_nonzero, clk, rst_n, hsv_valid && hsv.hue_defined, hsv.saturation != '0)
    `RHC_ASSERT_SAME(a_rem_below_div, clk, rst_n, s2_valid_reg && s2_reg.hue_defined, s2_reg.hue_rem < s2_reg.delta)
    `RHC_ASSERT_NEXT(a_stage1_holds, clk, rst_n, s1_valid_reg && !s2_ready, s1_valid_reg && $stable(s1_reg))

endmodule
